// ===== hdl/tcp_syn_option_parser_top_macros.svh =====
// Assertion macros for the TCP SYN option parser checker.
// Include by bare file name; no other dependencies.
`ifndef TCP_SYN_OPTION_PARSER_TOP_MACROS_SVH
`define TCP_SYN_OPTION_PARSER_TOP_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define TSOP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tsop assertion failed");

// Next-cycle implication, masked while reset is high.
`define TSOP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tsop assertion failed");

// Next-cycle implication that also checks across reset.
`define TSOP_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("tsop assertion failed");

`endif

// ===== hdl/tsop_pkg.sv =====
// Package for the TCP SYN option parser: widths, option kinds, register
// indexes, parse phase and result types. No dependencies.
`default_nettype none

package tsop_pkg;

   localparam int unsigned ByteW = 8;
   localparam int unsigned MssW  = 16;
   localparam int unsigned CsrIndexW = 1;

   // Option kinds
   localparam logic [ByteW-1:0] KIND_END    = 8'd0;
   localparam logic [ByteW-1:0] KIND_NOP    = 8'd1;
   localparam logic [ByteW-1:0] KIND_MSS    = 8'd2;
   localparam logic [ByteW-1:0] KIND_WSCALE = 8'd3;

   // Smallest legal record length (kind + length bytes)
   localparam logic [ByteW-1:0] MIN_REC_LEN = 8'd2;

   // Register indexes
   localparam logic [CsrIndexW-1:0] CSR_LOCAL_MSS        = 1'd0;
   localparam logic [CsrIndexW-1:0] CSR_DEFAULT_PEER_MSS = 1'd1;

   localparam logic [MssW-1:0] LOCAL_MSS_RESET        = 16'd1460;
   localparam logic [MssW-1:0] DEFAULT_PEER_MSS_RESET = 16'd536;

   typedef enum logic [1:0] {
      PH_KIND  = 2'd0,
      PH_LEN   = 2'd1,
      PH_VALUE = 2'd2,
      PH_STOP  = 2'd3
   } phase_type;

   // Value bytes seen, saturating: 0, 1, or two and more
   typedef logic [1:0] seen_type;
   localparam seen_type SEEN_NONE = 2'd0;
   localparam seen_type SEEN_ONE  = 2'd1;
   localparam seen_type SEEN_TWO  = 2'd2;

   typedef struct packed {
      logic [MssW-1:0]  peer_mss;
      logic             mss_found;
      logic [ByteW-1:0] window_shift;
      logic             shift_found;
      logic [MssW-1:0]  reply_mss;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/tsop_if.sv =====
// Request and response channel interfaces of the TCP SYN option parser.
// Depends on tsop_pkg.
`default_nettype none

interface tsop_req_if import tsop_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] option_byte;
   logic             last_byte;

   modport source (output valid, output option_byte, output last_byte, input ready);
   modport sink   (input valid, input option_byte, input last_byte, output ready);
endinterface

interface tsop_rsp_if import tsop_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [MssW-1:0]  peer_mss;
   logic             mss_found;
   logic [ByteW-1:0] window_shift;
   logic             shift_found;
   logic [MssW-1:0]  reply_mss;

   modport source (output valid, output peer_mss, output mss_found, output window_shift,
                   output shift_found, output reply_mss, input ready);
   modport sink   (input valid, input peer_mss, input mss_found, input window_shift,
                   input shift_found, input reply_mss, output ready);
endinterface

`default_nettype wire

// ===== hdl/tcp_syn_option_parser_top.sv =====
// Top level of the TCP SYN option parser: byte-wise option walk, found-value
// registers and a two-slot response buffer. Depends on tsop_pkg, tsop_if.
`default_nettype none

//  channel | direction | handshake     | payload
//  --------+-----------+---------------+--------------------------------------------
//  req_if  | in        | valid / ready | option_byte[7:0], last_byte
//  rsp_if  | out       | valid / ready | peer_mss, mss_found, window_shift,
//          |           |               | shift_found, reply_mss
//  csr_*   | in        | csr_we only   | csr_index (0 local MSS, 1 default peer MSS)
//
//  One option byte per cycle while ready is high; each request updates the parse state in
//  the cycle it is accepted, and a request marked last loads its result into the response
//  buffer.
//  The response side holds two results (output register plus skid slot), so requests
//  keep flowing while a result waits; req ready drops only when both slots are full.
//  Reset (synchronous, active high) clears the parse state, empties the buffer and
//  restores both registers to 1460 and 536.

module tcp_syn_option_parser_top
   import tsop_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   tsop_req_if.sink                  req_if,
   tsop_rsp_if.source                rsp_if,
   input  wire logic                 csr_we,
   input  wire logic [CsrIndexW-1:0] csr_index,
   input  wire logic [MssW-1:0]      csr_wdata
);

   // configuration registers
   logic [MssW-1:0] local_mss_ff;
   logic [MssW-1:0] default_mss_ff;

   // parse state
   phase_type        phase_ff,       phase_in;
   logic [ByteW-1:0] kind_ff,        kind_in;
   logic [ByteW-1:0] left_ff,        left_in;
   seen_type         seen_ff,        seen_in;
   logic [MssW-1:0]  partial_ff,     partial_in;
   logic             mss_valid_ff,   mss_valid_in;
   logic [MssW-1:0]  mss_value_ff,   mss_value_in;
   logic             shift_valid_ff, shift_valid_in;
   logic [ByteW-1:0] shift_value_ff, shift_value_in;

   // response buffer
   logic       head_valid_ff, skid_valid_ff;
   result_type head_ff,       skid_ff;
   result_type result;

   logic            req_fire;
   logic            rsp_fire;
   logic            push;
   logic            apply;
   logic [MssW-1:0] peer_sel;

   // Only a full skid slot blocks requests.
   assign req_if.ready = !skid_valid_ff;
   assign req_fire     = req_if.valid && req_if.ready;
   assign rsp_fire     = head_valid_ff && rsp_if.ready;
   assign push         = req_fire && req_if.last_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_mss_ff   <= LOCAL_MSS_RESET;
         default_mss_ff <= DEFAULT_PEER_MSS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOCAL_MSS:        local_mss_ff   <= csr_wdata;
            CSR_DEFAULT_PEER_MSS: default_mss_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Walk one option byte: next parse state, record apply, result fields.
   always_comb begin
      phase_in       = phase_ff;
      kind_in        = kind_ff;
      left_in        = left_ff;
      seen_in        = seen_ff;
      partial_in     = partial_ff;
      mss_valid_in   = mss_valid_ff;
      mss_value_in   = mss_value_ff;
      shift_valid_in = shift_valid_ff;
      shift_value_in = shift_value_ff;
      apply          = 1'b0;

      if (req_fire) begin
         unique case (phase_ff)
            PH_KIND: begin
               if (req_if.option_byte == KIND_END) begin
                  phase_in = PH_STOP;
               end else if (req_if.option_byte != KIND_NOP) begin
                  kind_in  = req_if.option_byte;
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               if (req_if.option_byte < MIN_REC_LEN) begin
                  phase_in = PH_STOP;    // short length: drop record, stop parse
               end else begin
                  left_in    = req_if.option_byte - MIN_REC_LEN;
                  seen_in    = SEEN_NONE;
                  partial_in = '0;
                  if (left_in == '0) begin
                     apply = 1'b1;
                  end else begin
                     phase_in = PH_VALUE;
                  end
               end
            end
            PH_VALUE: begin
               if (seen_ff == SEEN_NONE) begin
                  partial_in = {req_if.option_byte, {ByteW{1'b0}}};
               end else if (seen_ff == SEEN_ONE) begin
                  partial_in = {partial_ff[MssW-1:ByteW], req_if.option_byte};
               end
               if (seen_ff != SEEN_TWO) begin
                  seen_in = seen_ff + SEEN_ONE;
               end
               left_in = left_ff - 8'd1;
               if (left_in == '0) begin
                  apply = 1'b1;
               end
            end
            PH_STOP: ;
            default: ;
         endcase

         if (apply) begin
            phase_in = PH_KIND;
            if (kind_in == KIND_MSS && seen_in == SEEN_TWO) begin
               mss_valid_in = 1'b1;
               mss_value_in = partial_in;
            end else if (kind_in == KIND_WSCALE && seen_in != SEEN_NONE) begin
               shift_valid_in = 1'b1;
               shift_value_in = partial_in[MssW-1:ByteW];
            end
         end
      end

      // Result as seen after this byte
      peer_sel            = mss_valid_in ? mss_value_in : default_mss_ff;
      result.peer_mss     = mss_valid_in ? mss_value_in : '0;
      result.mss_found    = mss_valid_in;
      result.window_shift = shift_valid_in ? shift_value_in : '0;
      result.shift_found  = shift_valid_in;
      result.reply_mss    = (local_mss_ff < peer_sel) ? local_mss_ff : peer_sel;

      // Last byte: drop all parse state for the next SYN
      if (push) begin
         phase_in       = PH_KIND;
         kind_in        = '0;
         left_in        = '0;
         seen_in        = SEEN_NONE;
         partial_in     = '0;
         mss_valid_in   = 1'b0;
         mss_value_in   = '0;
         shift_valid_in = 1'b0;
         shift_value_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_KIND;
         kind_ff        <= '0;
         left_ff        <= '0;
         seen_ff        <= SEEN_NONE;
         partial_ff     <= '0;
         mss_valid_ff   <= 1'b0;
         mss_value_ff   <= '0;
         shift_valid_ff <= 1'b0;
         shift_value_ff <= '0;
      end else begin
         phase_ff       <= phase_in;
         kind_ff        <= kind_in;
         left_ff        <= left_in;
         seen_ff        <= seen_in;
         partial_ff     <= partial_in;
         mss_valid_ff   <= mss_valid_in;
         mss_value_ff   <= mss_value_in;
         shift_valid_ff <= shift_valid_in;
         shift_value_ff <= shift_value_in;
      end
   end

   // Response buffer: head drives the port, skid catches a result while head stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!head_valid_ff) begin
         head_valid_ff <= push;
      end else if (rsp_fire) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= push;
         end else begin
            head_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!head_valid_ff) begin
         head_ff <= result;
      end else if (rsp_fire) begin
         if (skid_valid_ff) begin
            head_ff <= skid_ff;
            skid_ff <= result;
         end else begin
            head_ff <= result;
         end
      end else if (push) begin
         skid_ff <= result;
      end
   end

   assign rsp_if.valid        = head_valid_ff;
   assign rsp_if.peer_mss     = head_ff.peer_mss;
   assign rsp_if.mss_found    = head_ff.mss_found;
   assign rsp_if.window_shift = head_ff.window_shift;
   assign rsp_if.shift_found  = head_ff.shift_found;
   assign rsp_if.reply_mss    = head_ff.reply_mss;

endmodule

`default_nettype wire

// ===== hdl/tsop_checker.sv =====
// Port-level checker for the TCP SYN option parser, bound to the top level.
// Depends on tsop_pkg and tcp_syn_option_parser_top_macros.svh.
`default_nettype none
`include "tcp_syn_option_parser_top_macros.svh"

module tsop_checker
   import tsop_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic [MssW-1:0]  peer_mss,
   input wire logic             mss_found,
   input wire logic [ByteW-1:0] window_shift,
   input wire logic             shift_found,
   input wire logic [MssW-1:0]  reply_mss
);

   // stalled response stays valid and holds peer_mss, reply_mss and window_shift
   `TSOP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(peer_mss) && $stable(reply_mss) && $stable(window_shift))
   // absent options report zero
   `TSOP_ASSERT_IMPLY(a_mss_zero, clock, reset, rsp_valid && !mss_found, peer_mss == '0)
   `TSOP_ASSERT_IMPLY(a_shift_zero, clock, reset, rsp_valid && !shift_found, window_shift == '0)
   // reply never exceeds the peer MSS it was built from
   `TSOP_ASSERT_IMPLY(a_reply_min, clock, reset, rsp_valid && mss_found, reply_mss <= peer_mss)
   // buffer empties on reset
   `TSOP_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind tcp_syn_option_parser_top tsop_checker u_tsop_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .peer_mss     (rsp_if.peer_mss),
   .mss_found    (rsp_if.mss_found),
   .window_shift (rsp_if.window_shift),
   .shift_found  (rsp_if.shift_found),
   .reply_mss    (rsp_if.reply_mss)
);

`default_nettype wire
